/* hdl/ssp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scaled sprite pixel writer package
// Shared constants, register indexes, interface structs and the panel write
// sequence table.
// ----------------------------------------------------------------------------
package ssp_pkg;

	localparam int SRC_PIXELS = 256;
	localparam int SRC_AW     = $clog2(SRC_PIXELS);
	localparam int COLOR_W    = 16;
	localparam int CRD_W      = 10;
	localparam int DIV_W      = CRD_W;
	localparam int DIV_CW     = $clog2(DIV_W + 1);

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_DRAW = 1'b1;

	localparam logic [2:0] CFG_SRC_SIDE      = 3'd0;
	localparam logic [2:0] CFG_DST_WIDTH     = 3'd1;
	localparam logic [2:0] CFG_DST_HEIGHT    = 3'd2;
	localparam logic [2:0] CFG_ORIGIN_X      = 3'd3;
	localparam logic [2:0] CFG_ORIGIN_Y      = 3'd4;
	localparam logic [2:0] CFG_SCREEN_WIDTH  = 3'd5;
	localparam logic [2:0] CFG_SCREEN_HEIGHT = 3'd6;
	localparam logic [2:0] CFG_KEY_ENABLE    = 3'd7;

	localparam logic [7:0]         CMD_COL_SET = 8'h2A;
	localparam logic [7:0]         CMD_ROW_SET = 8'h2B;
	localparam logic [7:0]         CMD_MEM_WR  = 8'h2C;
	localparam logic [COLOR_W-1:0] KEY_COLOR   = 16'hFFFF;

	typedef struct packed {
		logic [4:0]       src_side;
		logic [CRD_W-1:0] dst_width;
		logic [CRD_W-1:0] dst_height;
		logic [CRD_W-1:0] origin_x;
		logic [CRD_W-1:0] origin_y;
		logic [CRD_W-1:0] screen_width;
		logic [CRD_W-1:0] screen_height;
		logic             key_enable;
	} cfg_t;

	typedef struct packed {
		logic       strobe;
		logic [7:0] spi_byte;
		logic       byte_valid;
		logic       is_data;
		logic       end_select;
		logic       last;
		logic       frame_done;
	} res_t;

	typedef enum logic [3:0] {
		SEL_COL_CMD,
		SEL_ROW_CMD,
		SEL_WR_CMD,
		SEL_X_HI,
		SEL_X_LO,
		SEL_Y_HI,
		SEL_Y_LO,
		SEL_C_HI,
		SEL_C_LO
	} byte_sel_t;

	typedef struct packed {
		byte_sel_t sel;
		logic      is_data;
		logic      end_select;
	} seq_step_t;

	localparam int SEQ_LEN = 13;
	localparam int SEQ_CW  = $clog2(SEQ_LEN);
	localparam logic [SEQ_CW-1:0] SEQ_LAST = SEQ_CW'(SEQ_LEN - 1);

	localparam seq_step_t SEQ_ROM [SEQ_LEN] = '{
		seq_step_t'{SEL_COL_CMD, 1'b0, 1'b1},
		seq_step_t'{SEL_X_HI,    1'b1, 1'b0},
		seq_step_t'{SEL_X_LO,    1'b1, 1'b0},
		seq_step_t'{SEL_X_HI,    1'b1, 1'b0},
		seq_step_t'{SEL_X_LO,    1'b1, 1'b1},
		seq_step_t'{SEL_ROW_CMD, 1'b0, 1'b1},
		seq_step_t'{SEL_Y_HI,    1'b1, 1'b0},
		seq_step_t'{SEL_Y_LO,    1'b1, 1'b0},
		seq_step_t'{SEL_Y_HI,    1'b1, 1'b0},
		seq_step_t'{SEL_Y_LO,    1'b1, 1'b1},
		seq_step_t'{SEL_WR_CMD,  1'b0, 1'b1},
		seq_step_t'{SEL_C_HI,    1'b1, 1'b0},
		seq_step_t'{SEL_C_LO,    1'b1, 1'b1}
	};

endpackage

/* hdl/ssp_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ssp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* hdl/ssp_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring division, one quotient bit per cycle, done pulses when finished.
// ----------------------------------------------------------------------------
module ssp_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [ssp_pkg::DIV_W-1:0] dividend,
	input  logic [ssp_pkg::DIV_W-1:0] divisor,
	output logic                      done,
	output logic [ssp_pkg::DIV_W-1:0] quotient
);

	logic                       busy_q;
	logic                       done_q;
	logic [ssp_pkg::DIV_CW-1:0] cnt_q;
	logic [ssp_pkg::DIV_W-1:0]  rem_q;
	logic [ssp_pkg::DIV_W-1:0]  quo_q;
	logic [ssp_pkg::DIV_W-1:0]  dvs_q;
	logic [ssp_pkg::DIV_W:0]    trial;
	logic [ssp_pkg::DIV_W:0]    diff;
	logic                       ge;
	logic [ssp_pkg::DIV_W-1:0]  rem_nxt;

	assign trial   = {rem_q, quo_q[ssp_pkg::DIV_W-1]};
	assign diff    = trial - {1'b0, dvs_q};
	assign ge      = trial >= {1'b0, dvs_q};
	assign rem_nxt = ge ? diff[ssp_pkg::DIV_W-1:0] : trial[ssp_pkg::DIV_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			dvs_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= '0;
				quo_q  <= dividend;
				dvs_q  <= divisor;
			end else if (busy_q) begin
				rem_q <= rem_nxt;
				quo_q <= {quo_q[ssp_pkg::DIV_W-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ssp_pkg::DIV_CW'(ssp_pkg::DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* hdl/ssp_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Draw sequencer
// Walks the destination rectangle, runs the three divisions on the shared
// divider, reads the source pixel and emits the panel write words or one skip word.
// ----------------------------------------------------------------------------
module ssp_seq (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ssp_pkg::cfg_t             cfg,
	input  logic                      draw,
	output logic                      busy,
	output logic                      div_start,
	output logic [ssp_pkg::DIV_W-1:0] div_dividend,
	output logic [ssp_pkg::DIV_W-1:0] div_divisor,
	input  logic                      div_done,
	input  logic [ssp_pkg::DIV_W-1:0] div_quotient,
	output logic                      ram_re,
	output logic [ssp_pkg::SRC_AW-1:0] ram_raddr,
	input  logic [ssp_pkg::COLOR_W-1:0] ram_rdata,
	output ssp_pkg::res_t             res
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV_SCALE,
		S_DIV_ROW,
		S_DIV_COL,
		S_ADDR,
		S_READ,
		S_EMIT
	} state_t;

	state_t                        state_q;
	logic [ssp_pkg::CRD_W-1:0]     col_q;
	logic [ssp_pkg::CRD_W-1:0]     row_q;
	logic [ssp_pkg::CRD_W-1:0]     cur_col_q;
	logic [ssp_pkg::CRD_W-1:0]     cur_row_q;
	logic [4:0]                    side_q;
	logic [ssp_pkg::DIV_W-1:0]     scale_q;
	logic [ssp_pkg::DIV_W-1:0]     qrow_q;
	logic [ssp_pkg::DIV_W-1:0]     qcol_q;
	logic [ssp_pkg::CRD_W:0]       x_q;
	logic [ssp_pkg::CRD_W:0]       y_q;
	logic [ssp_pkg::COLOR_W-1:0]   color_q;
	logic                          skip_q;
	logic                          frame_q;
	logic [ssp_pkg::SEQ_CW-1:0]    cnt_q;
	ssp_pkg::res_t                 res_q;

	logic [4:0]                    side_eff;
	logic [ssp_pkg::CRD_W-1:0]     w_eff;
	logic [ssp_pkg::CRD_W-1:0]     h_eff;
	logic                          use_div;
	logic [ssp_pkg::DIV_W-1:0]     scale_now;
	logic [ssp_pkg::CRD_W-1:0]     col_inc;
	logic [ssp_pkg::CRD_W-1:0]     row_inc;
	logic                          col_wrap;
	logic                          row_wrap;
	logic [14:0]                   prod;
	logic [15:0]                   sum;
	logic                          skip_now;
	ssp_pkg::seq_step_t            step;
	logic [7:0]                    byte_now;

	assign side_eff  = (cfg.src_side == 5'd0) ? 5'd1 : cfg.src_side;
	assign w_eff     = (cfg.dst_width == '0) ? ssp_pkg::CRD_W'(1) : cfg.dst_width;
	assign h_eff     = (cfg.dst_height == '0) ? ssp_pkg::CRD_W'(1) : cfg.dst_height;
	assign use_div   = (w_eff == h_eff) && ({5'b0, side_eff} != w_eff);
	assign scale_now = (div_quotient == '0) ? ssp_pkg::DIV_W'(1) : div_quotient;

	assign col_inc  = col_q + 1'b1;
	assign row_inc  = row_q + 1'b1;
	assign col_wrap = col_inc >= w_eff;
	assign row_wrap = row_inc >= h_eff;

	assign prod      = {5'b0, qrow_q} * {10'b0, side_q};
	assign sum       = {1'b0, prod} + {6'b0, qcol_q};
	assign ram_raddr = sum[ssp_pkg::SRC_AW-1:0];
	assign ram_re    = (state_q == S_ADDR);

	assign skip_now = (x_q >= {1'b0, cfg.screen_width}) ||
		(y_q >= {1'b0, cfg.screen_height}) ||
		(cfg.key_enable && (ram_rdata == ssp_pkg::KEY_COLOR));

	always_comb begin
		div_start    = 1'b0;
		div_dividend = cur_row_q;
		div_divisor  = scale_now;
		unique case (state_q)
			S_IDLE: begin
				div_start    = draw;
				div_dividend = use_div ? w_eff : ssp_pkg::DIV_W'(1);
				div_divisor  = use_div ? {5'b0, side_eff} : ssp_pkg::DIV_W'(1);
			end
			S_DIV_SCALE: begin
				div_start    = div_done;
				div_dividend = cur_row_q;
				div_divisor  = scale_now;
			end
			S_DIV_ROW: begin
				div_start    = div_done;
				div_dividend = cur_col_q;
				div_divisor  = scale_q;
			end
			S_DIV_COL, S_ADDR, S_READ, S_EMIT: begin
				div_start = 1'b0;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	assign step = ssp_pkg::SEQ_ROM[cnt_q];

	always_comb begin
		unique case (step.sel)
			ssp_pkg::SEL_COL_CMD: byte_now = ssp_pkg::CMD_COL_SET;
			ssp_pkg::SEL_ROW_CMD: byte_now = ssp_pkg::CMD_ROW_SET;
			ssp_pkg::SEL_WR_CMD:  byte_now = ssp_pkg::CMD_MEM_WR;
			ssp_pkg::SEL_X_HI:    byte_now = {5'b0, x_q[ssp_pkg::CRD_W:8]};
			ssp_pkg::SEL_X_LO:    byte_now = x_q[7:0];
			ssp_pkg::SEL_Y_HI:    byte_now = {5'b0, y_q[ssp_pkg::CRD_W:8]};
			ssp_pkg::SEL_Y_LO:    byte_now = y_q[7:0];
			ssp_pkg::SEL_C_HI:    byte_now = color_q[15:8];
			ssp_pkg::SEL_C_LO:    byte_now = color_q[7:0];
			default:              byte_now = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			col_q     <= '0;
			row_q     <= '0;
			cur_col_q <= '0;
			cur_row_q <= '0;
			side_q    <= '0;
			scale_q   <= '0;
			qrow_q    <= '0;
			qcol_q    <= '0;
			x_q       <= '0;
			y_q       <= '0;
			color_q   <= '0;
			skip_q    <= 1'b0;
			frame_q   <= 1'b0;
			cnt_q     <= '0;
			res_q     <= '0;
		end else begin
			res_q.strobe <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (draw) begin
						cur_col_q <= col_q;
						cur_row_q <= row_q;
						side_q    <= side_eff;
						x_q       <= {1'b0, cfg.origin_x} + {1'b0, col_q};
						y_q       <= {1'b0, cfg.origin_y} + {1'b0, row_q};
						frame_q   <= 1'b0;
						if (col_wrap) begin
							col_q <= '0;
							if (row_wrap) begin
								row_q   <= '0;
								frame_q <= 1'b1;
							end else begin
								row_q <= row_inc;
							end
						end else begin
							col_q <= col_inc;
						end
						state_q <= S_DIV_SCALE;
					end
				end
				S_DIV_SCALE: begin
					if (div_done) begin
						scale_q <= scale_now;
						state_q <= S_DIV_ROW;
					end
				end
				S_DIV_ROW: begin
					if (div_done) begin
						qrow_q  <= div_quotient;
						state_q <= S_DIV_COL;
					end
				end
				S_DIV_COL: begin
					if (div_done) begin
						qcol_q  <= div_quotient;
						state_q <= S_ADDR;
					end
				end
				S_ADDR: begin
					state_q <= S_READ;
				end
				S_READ: begin
					color_q <= ram_rdata;
					skip_q  <= skip_now;
					cnt_q   <= '0;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					res_q.strobe <= 1'b1;
					if (skip_q) begin
						res_q.spi_byte   <= 8'h00;
						res_q.byte_valid <= 1'b0;
						res_q.is_data    <= 1'b0;
						res_q.end_select <= 1'b0;
						res_q.last       <= 1'b1;
						res_q.frame_done <= frame_q;
						state_q          <= S_IDLE;
					end else begin
						res_q.spi_byte   <= byte_now;
						res_q.byte_valid <= 1'b1;
						res_q.is_data    <= step.is_data;
						res_q.end_select <= step.end_select;
						res_q.last       <= (cnt_q == ssp_pkg::SEQ_LAST);
						res_q.frame_done <= (cnt_q == ssp_pkg::SEQ_LAST) && frame_q;
						cnt_q            <= cnt_q + 1'b1;
						if (cnt_q == ssp_pkg::SEQ_LAST) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign res  = res_q;

endmodule

/* hdl/scaled_sprite_pixel_writer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scaled sprite pixel writer
// A load word writes one pixel of the source image and leaves the block ready.
// A draw word runs three divisions on the shared divider, one RAM read, then
// 13 result words on consecutive cycles for a drawn pixel or one skip word for
// a skipped one; a new word is taken only once the block is idle again.
// Results cannot be stalled. Reset clears the walk counters and loads the
// register defaults; the image RAM holds no reset value.
// ----------------------------------------------------------------------------
module scaled_sprite_pixel_writer_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        req_type,
	input  logic [7:0]                  src_index,
	input  logic [15:0]                 src_color,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [2:0]                  cfg_index,
	input  logic [ssp_pkg::CRD_W-1:0]   cfg_data,
	output logic                        strobe,
	output logic [7:0]                  spi_byte,
	output logic                        byte_valid,
	output logic                        is_data,
	output logic                        end_select,
	output logic                        last,
	output logic                        frame_done
);

	ssp_pkg::cfg_t                 cfg_q;
	ssp_pkg::res_t                 res;
	logic                          accept;
	logic                          load_we;
	logic                          draw;
	logic                          div_start;
	logic [ssp_pkg::DIV_W-1:0]     div_dividend;
	logic [ssp_pkg::DIV_W-1:0]     div_divisor;
	logic                          div_done;
	logic [ssp_pkg::DIV_W-1:0]     div_quotient;
	logic                          ram_re;
	logic [ssp_pkg::SRC_AW-1:0]    ram_raddr;
	logic [ssp_pkg::COLOR_W-1:0]   ram_rdata;

	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign load_we   = accept && (req_type == ssp_pkg::REQ_LOAD) &&
		({1'b0, src_index} < 9'(ssp_pkg::SRC_PIXELS));
	assign draw      = accept && (req_type == ssp_pkg::REQ_DRAW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src_side      <= 5'd10;
			cfg_q.dst_width     <= 10'd10;
			cfg_q.dst_height    <= 10'd10;
			cfg_q.origin_x      <= 10'd0;
			cfg_q.origin_y      <= 10'd0;
			cfg_q.screen_width  <= 10'd240;
			cfg_q.screen_height <= 10'd320;
			cfg_q.key_enable    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ssp_pkg::CFG_SRC_SIDE:      cfg_q.src_side      <= cfg_data[4:0];
				ssp_pkg::CFG_DST_WIDTH:     cfg_q.dst_width     <= cfg_data;
				ssp_pkg::CFG_DST_HEIGHT:    cfg_q.dst_height    <= cfg_data;
				ssp_pkg::CFG_ORIGIN_X:      cfg_q.origin_x      <= cfg_data;
				ssp_pkg::CFG_ORIGIN_Y:      cfg_q.origin_y      <= cfg_data;
				ssp_pkg::CFG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data;
				ssp_pkg::CFG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data;
				ssp_pkg::CFG_KEY_ENABLE:    cfg_q.key_enable    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	ssp_ram #(
		.WIDTH(ssp_pkg::COLOR_W),
		.DEPTH(ssp_pkg::SRC_PIXELS)
	) u_image (
		.clk   (clk),
		.we    (load_we),
		.waddr (src_index[ssp_pkg::SRC_AW-1:0]),
		.wdata (src_color),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	ssp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	ssp_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.draw         (draw),
		.busy         (busy),
		.div_start    (div_start),
		.div_dividend (div_dividend),
		.div_divisor  (div_divisor),
		.div_done     (div_done),
		.div_quotient (div_quotient),
		.ram_re       (ram_re),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata),
		.res          (res)
	);

	assign strobe     = res.strobe;
	assign spi_byte   = res.spi_byte;
	assign byte_valid = res.byte_valid;
	assign is_data    = res.is_data;
	assign end_select = res.end_select;
	assign last       = res.last;
	assign frame_done = res.frame_done;

endmodule

/* hdl/ssp_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scaled sprite pixel writer port checker
// Watches the top-level ports for the draw handshake and ordering rules of the result words.
// ----------------------------------------------------------------------------
module ssp_chk (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic req_type,
	input logic strobe,
	input logic byte_valid,
	input logic last,
	input logic frame_done
);

	a_draw_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (req_type == ssp_pkg::REQ_DRAW) |=> busy)
		else $error("Draw word accepted but block not busy.");

	a_skip_single: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !byte_valid |-> last)
		else $error("Empty word is not the last of its run.");

	a_frame_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && frame_done |-> last)
		else $error("Frame done outside the last word of a run.");

	a_run_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !strobe)
		else $error("Word follows the last word of a run.");

	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy)
		else $error("Block idle in the middle of a run.");

endmodule

bind scaled_sprite_pixel_writer_unit ssp_chk u_ssp_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.req_type   (req_type),
	.strobe     (strobe),
	.byte_valid (byte_valid),
	.last       (last),
	.frame_done (frame_done)
);

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scaled sprite pixel writer testbench
// Loads source pixels and steps the destination walk through a series of
// register settings, from the reset values to the extremes: zero sizes, the
// full 10-bit range, screen clipping on both axes and the transparent color.
// A scoreboard tracks the image, the walk counters and the registers. It
// predicts every panel byte word or skip word and checks each word the block
// emits against the oldest prediction.
// ----------------------------------------------------------------------------

class pixel_scoreboard;

	ssp_pkg::cfg_t   regs;
	logic [15:0]     image [ssp_pkg::SRC_PIXELS];
	bit              written [ssp_pkg::SRC_PIXELS];
	logic [9:0]      col;
	logic [9:0]      row;
	ssp_pkg::res_t   bytes_due [$];
	int unsigned     errors;

	function new();
		regs = '{src_side: 5'd10, dst_width: 10'd10, dst_height: 10'd10,
			origin_x: 10'd0, origin_y: 10'd0, screen_width: 10'd240,
			screen_height: 10'd320, key_enable: 1'b0};
		col = '0;
		row = '0;
		errors = 0;
		foreach (written[i]) written[i] = 1'b0;
	endfunction

	function int unsigned at_least_one(int unsigned v);
		return (v != 0) ? v : 1;
	endfunction

	function void write_reg(logic [2:0] idx, logic [9:0] value);
		case (idx)
			ssp_pkg::CFG_SRC_SIDE:      regs.src_side      = value[4:0];
			ssp_pkg::CFG_DST_WIDTH:     regs.dst_width     = value;
			ssp_pkg::CFG_DST_HEIGHT:    regs.dst_height    = value;
			ssp_pkg::CFG_ORIGIN_X:      regs.origin_x      = value;
			ssp_pkg::CFG_ORIGIN_Y:      regs.origin_y      = value;
			ssp_pkg::CFG_SCREEN_WIDTH:  regs.screen_width  = value;
			ssp_pkg::CFG_SCREEN_HEIGHT: regs.screen_height = value;
			ssp_pkg::CFG_KEY_ENABLE:    regs.key_enable    = value[0];
			default: ;
		endcase
	endfunction

	function int unsigned sample_index();
		int unsigned side;
		int unsigned w;
		int unsigned h;
		int unsigned scale;
		side = at_least_one(regs.src_side);
		w = at_least_one(regs.dst_width);
		h = at_least_one(regs.dst_height);
		scale = 1;
		if (w == h && side != w)
			scale = w / side;
		if (scale == 0)
			scale = 1;
		return ((row / scale) * side + col / scale) % ssp_pkg::SRC_PIXELS;
	endfunction

	function void push_word(logic [7:0] b, logic valid, logic data, logic endsel,
			logic lst, logic done);
		bytes_due.push_back('{1'b1, b, valid, data, endsel, lst, done});
	endfunction

	function void note_word(logic req, logic [7:0] idx, logic [15:0] color);
		int unsigned w;
		int unsigned h;
		int unsigned x;
		int unsigned y;
		logic [15:0] pix;
		logic done;
		if (req == ssp_pkg::REQ_LOAD) begin
			image[idx] = color;
			written[idx] = 1'b1;
			return;
		end
		w = at_least_one(regs.dst_width);
		h = at_least_one(regs.dst_height);
		pix = image[sample_index()];
		x = regs.origin_x + col;
		y = regs.origin_y + row;
		done = 1'b0;
		col = col + 10'd1;
		if (col >= w) begin
			col = '0;
			row = row + 10'd1;
			if (row >= h) begin
				row = '0;
				done = 1'b1;
			end
		end
		if (x >= regs.screen_width || y >= regs.screen_height ||
				(regs.key_enable && pix == ssp_pkg::KEY_COLOR)) begin
			push_word(8'h00, 1'b0, 1'b0, 1'b0, 1'b1, done);
			return;
		end
		push_word(ssp_pkg::CMD_COL_SET, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
		push_word(8'(x >> 8), 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
		push_word(8'(x), 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
		push_word(8'(x >> 8), 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
		push_word(8'(x), 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
		push_word(ssp_pkg::CMD_ROW_SET, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
		push_word(8'(y >> 8), 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
		push_word(8'(y), 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
		push_word(8'(y >> 8), 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
		push_word(8'(y), 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
		push_word(ssp_pkg::CMD_MEM_WR, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
		push_word(pix[15:8], 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
		push_word(pix[7:0], 1'b1, 1'b1, 1'b1, 1'b1, done);
	endfunction

	task report(string msg);
		$display("%0t mismatch: %s", $realtime, msg);
		errors++;
	endtask

	task compare_field(string name, logic [7:0] got, logic [7:0] want);
		if (got !== want)
			report($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	task check_result(ssp_pkg::res_t got);
		ssp_pkg::res_t want;
		if (bytes_due.size() == 0) begin
			report($sformatf("unexpected word, byte %0h", got.spi_byte));
			return;
		end
		want = bytes_due.pop_front();
		compare_field("spi_byte", got.spi_byte, want.spi_byte);
		compare_field("byte_valid", 8'(got.byte_valid), 8'(want.byte_valid));
		compare_field("is_data", 8'(got.is_data), 8'(want.is_data));
		compare_field("end_select", 8'(got.end_select), 8'(want.end_select));
		compare_field("last", 8'(got.last), 8'(want.last));
		compare_field("frame_done", 8'(got.frame_done), 8'(want.frame_done));
	endtask

endclass

module tb;

	localparam int STALL_LIMIT = 1000;
	localparam int ITEM_TARGET = 380;
	localparam int IDLE_PAUSE  = 50;

	logic                      clk        = 1'b0;
	logic                      arst_n     = 1'b0;
	logic                      start      = 1'b0;
	logic                      busy;
	logic                      req_type   = 1'b0;
	logic [7:0]                src_index  = '0;
	logic [15:0]               src_color  = '0;
	logic                      cfg_valid  = 1'b0;
	logic                      cfg_ready;
	logic [2:0]                cfg_index  = '0;
	logic [ssp_pkg::CRD_W-1:0] cfg_data   = '0;
	logic                      strobe;
	logic [7:0]                spi_byte;
	logic                      byte_valid;
	logic                      is_data;
	logic                      end_select;
	logic                      last;
	logic                      frame_done;

	pixel_scoreboard  sb;
	int unsigned      items_sent   = 0;
	int unsigned      burst_left   = 0;
	int unsigned      stall_cycles = 0;

	scaled_sprite_pixel_writer_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req_type   (req_type),
		.src_index  (src_index),
		.src_color  (src_color),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.strobe     (strobe),
		.spi_byte   (spi_byte),
		.byte_valid (byte_valid),
		.is_data    (is_data),
		.end_select (end_select),
		.last       (last),
		.frame_done (frame_done)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && strobe)
			sb.check_result('{strobe, spi_byte, byte_valid, is_data, end_select, last,
				frame_done});
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || (cfg_valid && cfg_ready) || strobe) begin
			stall_cycles <= 0;
		end else if (stall_cycles == STALL_LIMIT) begin
			$display("tb: errors");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic logic [15:0] pick_color();
		case ($urandom_range(0, 5))
			0: return ssp_pkg::KEY_COLOR;
			1: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_word(logic req, logic [7:0] idx, logic [15:0] color);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 8);
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
				: $urandom_range(1, 8);
		end
		burst_left--;
		@(negedge clk);
		start     <= 1'b1;
		req_type  <= req;
		src_index <= idx;
		src_color <= color;
		do @(posedge clk); while (busy);
		sb.note_word(req, idx, color);
		items_sent++;
	endtask

	task automatic load_pixel(logic [7:0] idx, logic [15:0] color);
		send_word(ssp_pkg::REQ_LOAD, idx, color);
	endtask

	task automatic draw_pixel(bit may_reload);
		int unsigned addr;
		addr = sb.sample_index();
		if (!sb.written[addr] || (may_reload && $urandom_range(0, 2) == 0))
			load_pixel(8'(addr), pick_color());
		send_word(ssp_pkg::REQ_DRAW, 8'($urandom), 16'($urandom));
	endtask

	task automatic wait_idle();
		@(negedge clk);
		start <= 1'b0;
		while (sb.bytes_due.size() != 0) @(posedge clk);
		repeat (IDLE_PAUSE) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic cfg_write(logic [2:0] idx, logic [ssp_pkg::CRD_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, value);
	endtask

	task automatic set_all(logic [4:0] side, logic [9:0] w, logic [9:0] h,
			logic [9:0] ox, logic [9:0] oy, logic [9:0] sw, logic [9:0] sh, logic key);
		cfg_write(ssp_pkg::CFG_SRC_SIDE, {5'($urandom), side});
		cfg_write(ssp_pkg::CFG_DST_WIDTH, w);
		cfg_write(ssp_pkg::CFG_DST_HEIGHT, h);
		cfg_write(ssp_pkg::CFG_ORIGIN_X, ox);
		cfg_write(ssp_pkg::CFG_ORIGIN_Y, oy);
		cfg_write(ssp_pkg::CFG_SCREEN_WIDTH, sw);
		cfg_write(ssp_pkg::CFG_SCREEN_HEIGHT, sh);
		cfg_write(ssp_pkg::CFG_KEY_ENABLE, {9'($urandom), key});
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_setting();
		logic [4:0] side;
		logic [9:0] w;
		logic [9:0] h;
		logic [9:0] ox;
		logic [9:0] oy;
		logic [9:0] sw;
		logic [9:0] sh;
		case ($urandom_range(0, 9))
			0:       side = 5'd0;
			1:       side = 5'($urandom_range(17, 31));
			default: side = 5'($urandom_range(1, 16));
		endcase
		case ($urandom_range(0, 5))
			0, 1: begin
				w = 10'(side * $urandom_range(1, 3));
				h = w;
			end
			2: begin
				w = 10'($urandom_range(0, 8));
				h = w;
			end
			3, 4: begin
				w = 10'($urandom_range(1, 8));
				h = 10'($urandom_range(1, 6));
			end
			default: begin
				w = 10'h3FF;
				h = ($urandom_range(0, 1) == 0) ? 10'h3FF : 10'd1;
			end
		endcase
		case ($urandom_range(0, 3))
			0:       ox = 10'($urandom);
			1:       ox = 10'h3FF;
			default: ox = 10'($urandom_range(0, 20));
		endcase
		case ($urandom_range(0, 3))
			0:       oy = 10'($urandom);
			1:       oy = 10'h3FF;
			default: oy = 10'($urandom_range(0, 20));
		endcase
		sw = ($urandom_range(0, 2) == 0) ? 10'($urandom_range(1, 30)) : 10'h3FF;
		sh = ($urandom_range(0, 2) == 0) ? 10'($urandom_range(1, 30)) : 10'h3FF;
		set_all(side, w, h, ox, oy, sw, sh, 1'($urandom));
	endtask

	initial begin
		int unsigned n;
		sb = new();
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		load_pixel(8'd255, ssp_pkg::KEY_COLOR);
		load_pixel(8'd0, 16'h0000);
		load_pixel(8'd1, ssp_pkg::KEY_COLOR);
		draw_pixel(0);
		draw_pixel(0);

		wait_idle();
		set_all(5'd10, 10'd10, 10'd10, 10'd1000, 10'd1013, 10'h3FF, 10'h3FF, 1'b1);
		load_pixel(8'd2, ssp_pkg::KEY_COLOR);
		draw_pixel(0);
		load_pixel(8'd3, 16'h5AA5);
		draw_pixel(0);

		wait_idle();
		set_all(5'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'h3FF, 10'h3FF, 1'b0);
		draw_pixel(0);
		draw_pixel(0);

		wait_idle();
		set_all(5'd16, 10'd16, 10'd16, 10'h3FF, 10'd0, 10'h3FF, 10'h3FF, 1'b0);
		draw_pixel(0);

		wait_idle();
		set_all(5'd16, 10'd32, 10'd32, 10'd0, 10'd5, 10'h3FF, 10'd1, 1'b0);
		draw_pixel(0);

		while (items_sent < ITEM_TARGET) begin
			wait_idle();
			random_setting();
			n = $urandom_range(15, 40);
			repeat (n) begin
				if ($urandom_range(0, 4) == 0)
					load_pixel(8'($urandom), pick_color());
				else
					draw_pixel(1);
			end
		end

		wait_idle();
		if (sb.errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
